>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSME_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSME_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ssme_pkg.sv
// ----------------------------------------------------------------------------
// ssme_pkg
// constants, operation codes and shared types of the sorted set merge engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssme_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam int OP_W       = 2;

    // byte address of set_operation
    localparam logic [APB_ADDR_W-1:0] SET_OP_ADDR = '0;

    typedef enum logic [OP_W-1:0] {
        OP_MERGE     = 2'd0,
        OP_UNION     = 2'd1,
        OP_INTERSECT = 2'd2,
        OP_DIFF      = 2'd3
    } set_op_t;

    // walker status toward the top level
    typedef struct packed {
        logic busy;    // walk in progress, no new transaction taken
        logic finish;  // final result pushed this cycle
    } walk_status_t;

endpackage

>>> design/sorted_set_merge_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_set_merge_engine_core: loads are taken back to back between walks
// a go walks both lists one step per cycle, while the result side keeps up,
// through the single read port of each list ram
// async active-low reset clears counts, overflow flag, operation and outputs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_set_merge_engine_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ssme_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ssme_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ssme_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               go,
    input  logic                               list_select,
    input  logic signed [ssme_pkg::DATA_W-1:0] value,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [ssme_pkg::DATA_W-1:0] result_value,
    output logic                               last,
    output logic                               empty_res,
    output logic                               overflow
);

    ssme_pkg::set_op_t                 op_reg;
    logic [ssme_pkg::CNT_W-1:0]        first_count_reg;
    logic [ssme_pkg::CNT_W-1:0]        second_count_reg;
    logic                              dropped_reg;

    ssme_pkg::walk_status_t            status;
    logic                              item_take, load, start;
    logic                              first_full, second_full;
    logic                              first_we, second_we;
    logic [ssme_pkg::IDX_W-1:0]        a_addr, b_addr;
    logic [ssme_pkg::DATA_W-1:0]       a_data, b_data;
    logic [ssme_pkg::DATA_W-1:0]       walk_value;
    logic                              cfg_write;

    // ---------------- configuration ----------------
    // a single register: write transactions at its address land in set_operation
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ssme_pkg::SET_OP_ADDR);
    assign prdata    = {{(ssme_pkg::APB_DATA_W - ssme_pkg::OP_W){1'b0}}, op_reg};

    // ---------------- item channel ----------------
    // items are taken only between walks
    assign item_stall = status.busy;
    assign item_take  = item_valid && !item_stall;
    assign load       = item_take && !go;
    assign start      = item_take && go;

    assign first_full  = (first_count_reg  >= ssme_pkg::CNT_W'(ssme_pkg::LIST_DEPTH));
    assign second_full = (second_count_reg >= ssme_pkg::CNT_W'(ssme_pkg::LIST_DEPTH));
    assign first_we    = load && !list_select && !first_full;
    assign second_we   = load &&  list_select && !second_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg           <= ssme_pkg::OP_MERGE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                op_reg <= ssme_pkg::set_op_t'(pwdata[ssme_pkg::OP_W-1:0]);
            end
            if (status.finish)
            begin
                // walk done: lists emptied, overflow flag cleared
                first_count_reg  <= '0;
                second_count_reg <= '0;
                dropped_reg      <= 1'b0;
            end
            else
            begin
                if (first_we)
                begin
                    first_count_reg <= first_count_reg + ssme_pkg::CNT_W'(1);
                end
                if (second_we)
                begin
                    second_count_reg <= second_count_reg + ssme_pkg::CNT_W'(1);
                end
                if (load && ((!list_select && first_full) || (list_select && second_full)))
                begin
                    dropped_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------- list memories ----------------
    // append at the fill count, read at the walk pointers
    ssme_ram #(
        .WIDTH (ssme_pkg::DATA_W),
        .DEPTH (ssme_pkg::LIST_DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (first_count_reg[ssme_pkg::IDX_W-1:0]),
        .wdata (value),
        .raddr (a_addr),
        .rdata (a_data)
    );

    ssme_ram #(
        .WIDTH (ssme_pkg::DATA_W),
        .DEPTH (ssme_pkg::LIST_DEPTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (second_count_reg[ssme_pkg::IDX_W-1:0]),
        .wdata (value),
        .raddr (b_addr),
        .rdata (b_data)
    );

    // ---------------- walker and result stage ----------------
    // counts and flag stay still during a walk since no item is taken
    ssme_walk u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op_reg),
        .n1           (first_count_reg),
        .n2           (second_count_reg),
        .ovf_in       (dropped_reg),
        .a_data       (a_data),
        .b_data       (b_data),
        .a_addr       (a_addr),
        .b_addr       (b_addr),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_value (walk_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow)
    );

    assign result_value = $signed(walk_value);

endmodule

>>> design/ssme_ram.sv
// ----------------------------------------------------------------------------
// ssme_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/ssme_walk.sv
// ----------------------------------------------------------------------------
// ssme_walk
// two-pointer walk over both list memories, one step per cycle unless stalled,
// with a one-entry hold stage so the final result can be marked last
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssme_walk (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  ssme_pkg::set_op_t            op,
    input  logic [ssme_pkg::CNT_W-1:0]   n1,
    input  logic [ssme_pkg::CNT_W-1:0]   n2,
    input  logic                         ovf_in,
    input  logic [ssme_pkg::DATA_W-1:0]  a_data,
    input  logic [ssme_pkg::DATA_W-1:0]  b_data,
    output logic [ssme_pkg::IDX_W-1:0]   a_addr,
    output logic [ssme_pkg::IDX_W-1:0]   b_addr,
    output ssme_pkg::walk_status_t       status,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [ssme_pkg::DATA_W-1:0]  result_value,
    output logic                         last,
    output logic                         empty_res,
    output logic                         overflow
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t                        state_reg;
    logic [ssme_pkg::CNT_W-1:0]    i_reg, i_next;
    logic [ssme_pkg::CNT_W-1:0]    j_reg, j_next;
    logic                          hold_valid_reg;
    logic [ssme_pkg::DATA_W-1:0]   hold_value_reg;
    logic                          ovf_reg;
    logic                          result_valid_reg;
    logic [ssme_pkg::DATA_W-1:0]   result_value_reg;
    logic                          last_reg;
    logic                          empty_reg;
    logic                          result_ovf_reg;

    logic                          a_ok, b_ok, a_lt, b_lt;
    logic                          emit, adv_i, adv_j, done;
    logic [ssme_pkg::DATA_W-1:0]   cand;
    logic                          out_free, step, finish;

    always_comb
    begin
        a_ok  = (i_reg < n1);
        b_ok  = (j_reg < n2);
        a_lt  = ($signed(a_data) < $signed(b_data));
        b_lt  = ($signed(b_data) < $signed(a_data));
        emit  = 1'b0;
        adv_i = 1'b0;
        adv_j = 1'b0;
        done  = 1'b0;
        cand  = a_data;
        if (a_ok && b_ok)
        begin
            if (a_lt)
            begin
                emit  = (op != ssme_pkg::OP_INTERSECT);
                adv_i = 1'b1;
            end
            else if (b_lt)
            begin
                emit  = (op == ssme_pkg::OP_MERGE) || (op == ssme_pkg::OP_UNION);
                cand  = b_data;
                adv_j = 1'b1;
            end
            else
            begin
                case (op)
                    ssme_pkg::OP_MERGE:
                    begin
                        emit  = 1'b1;
                        cand  = b_data;
                        adv_j = 1'b1;
                    end
                    ssme_pkg::OP_UNION, ssme_pkg::OP_INTERSECT:
                    begin
                        emit  = 1'b1;
                        adv_i = 1'b1;
                        adv_j = 1'b1;
                    end
                    default:
                    begin
                        adv_i = 1'b1;
                        adv_j = 1'b1;
                    end
                endcase
            end
        end
        else if (a_ok && (op != ssme_pkg::OP_INTERSECT))
        begin
            emit  = 1'b1;
            adv_i = 1'b1;
        end
        else if (b_ok && ((op == ssme_pkg::OP_MERGE) || (op == ssme_pkg::OP_UNION)))
        begin
            emit  = 1'b1;
            cand  = b_data;
            adv_j = 1'b1;
        end
        else
        begin
            done = 1'b1;
        end
    end

    assign out_free = !result_valid_reg || !result_stall;
    // a step that emits must first move the held result out
    assign step   = (state_reg == ST_WALK) && !done
                    && (!emit || !hold_valid_reg || out_free);
    assign finish = (state_reg == ST_WALK) && done && out_free;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (step)
        begin
            i_next = i_reg + ssme_pkg::CNT_W'(adv_i);
            j_next = j_reg + ssme_pkg::CNT_W'(adv_j);
        end
        else
        begin
            i_next = i_reg;
            j_next = j_reg;
        end
    end

    // read addresses follow the next pointers so data lines up with i_reg, j_reg
    assign a_addr = i_next[ssme_pkg::IDX_W-1:0];
    assign b_addr = j_next[ssme_pkg::IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            hold_valid_reg   <= 1'b0;
            hold_value_reg   <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            result_value_reg <= '0;
            last_reg         <= 1'b0;
            empty_reg        <= 1'b0;
            result_ovf_reg   <= 1'b0;
        end
        else
        begin
            i_reg <= i_next;
            j_reg <= j_next;
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg      <= ST_WALK;
                        hold_valid_reg <= 1'b0;
                        ovf_reg        <= ovf_in;
                    end
                end
                ST_WALK:
                begin
                    if (step && emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            result_valid_reg <= 1'b1;
                            result_value_reg <= hold_value_reg;
                            last_reg         <= 1'b0;
                            empty_reg        <= 1'b0;
                            result_ovf_reg   <= ovf_reg;
                        end
                        hold_valid_reg <= 1'b1;
                        hold_value_reg <= cand;
                    end
                    if (finish)
                    begin
                        result_valid_reg <= 1'b1;
                        last_reg         <= 1'b1;
                        result_ovf_reg   <= ovf_reg;
                        if (hold_valid_reg)
                        begin
                            result_value_reg <= hold_value_reg;
                            empty_reg        <= 1'b0;
                        end
                        else
                        begin
                            result_value_reg <= '0;
                            empty_reg        <= 1'b1;
                        end
                        hold_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign status.busy   = (state_reg != ST_IDLE);
    assign status.finish = finish;
    assign result_valid  = result_valid_reg;
    assign result_value  = result_value_reg;
    assign last          = last_reg;
    assign empty_res     = empty_reg;
    assign overflow      = result_ovf_reg;

endmodule

>>> design/ssme_checker.sv
// ----------------------------------------------------------------------------
// ssme_checker
// port-level checks of the sorted set merge engine, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssme_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_stall,
    input logic                              go,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic [ssme_pkg::DATA_W-1:0]       result_value,
    input logic                              last,
    input logic                              empty_res
);

    // stalled result transaction holds
    `SSME_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_value) && $stable(last), "result changed while stalled")

    // empty report is a single final zero item
    `SSME_ASSERT_IMP(a_empty_form, result_valid && empty_res, last && (result_value == '0), "empty result item malformed")

    // an accepted go starts a walk that holds off further items
    `SSME_ASSERT_NXT(a_go_busy, item_valid && !item_stall && go, item_stall, "no walk after go")

    // a result that is not last means the walk is still running
    `SSME_ASSERT_IMP(a_mid_walk, result_valid && !last, item_stall, "non-last result outside a walk")

endmodule

bind sorted_set_merge_engine_core ssme_checker u_ssme_checker (.*);

>>> tb/sv/sorted_set_merge_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_merge_engine_core_test
// loads two lists, runs walks under all four set operations and checks every
// result transaction against a predictor kept inside the bench; sender bursts
// and receiver stalls are randomized, with one long receiver hold-off
// ----------------------------------------------------------------------------

module sorted_set_merge_engine_core_test;

    import ssme_pkg::*;

    // bench timing
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;  // one full walk and some
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 420;
    localparam int PHASE_ITEMS   = 55;

    // register map: set_operation is the only register, at byte address 0
    localparam logic [APB_ADDR_W-1:0] REG_SET_OP = '0;

    typedef logic signed [DATA_W-1:0] elem_q_t[$];

    // one input transaction: a load or a go
    typedef struct packed {
        logic                     go;
        logic                     list_select;
        logic signed [DATA_W-1:0] value;
    } engine_item_t;

    // one result transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     last;
        logic                     empty_res;
        logic                     overflow;
    } merge_out_t;

    // dut connections, all inputs known from time zero
    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr        = '0;
    logic [APB_DATA_W-1:0]    pwdata       = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;
    logic                     item_valid   = 1'b0;
    logic                     item_stall;
    logic                     go           = 1'b0;
    logic                     list_select  = 1'b0;
    logic signed [DATA_W-1:0] value        = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [DATA_W-1:0] result_value;
    logic                     last;
    logic                     empty_res;
    logic                     overflow;

    sorted_set_merge_engine_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .go           (go),
        .list_select  (list_select),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_value (result_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: its own copy of both lists, counts, flag and mode
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] first_list  [LIST_DEPTH];
    logic signed [DATA_W-1:0] second_list [LIST_DEPTH];
    int unsigned              first_count  = 0;
    int unsigned              second_count = 0;
    logic                     dropped_flag = 1'b0;
    set_op_t                  active_op    = OP_MERGE;

    merge_out_t   predicted_elements[$];   // results still owed by the dut
    engine_item_t items_to_send[$];        // transactions not yet offered
    int           items_queued   = 0;
    int           items_accepted = 0;
    int           mismatch_count = 0;
    int           cycle_count    = 0;

    // sender pacing
    int           burst_left     = 8;
    int           gap_left       = 0;
    engine_item_t accepted_item;
    engine_item_t next_item;

    // receiver pacing; the stimulus asks for a long hold-off by bumping
    // hold_requests, the receiver grants it once per bump
    int           hold_requests  = 0;
    int           hold_grants    = 0;
    int           hold_left      = 0;
    int           window_left    = 0;
    int           stall_pct      = 0;

    function automatic merge_out_t element_out(logic signed [DATA_W-1:0] v);
        merge_out_t r;
        r.result_value = v;
        r.last         = 1'b0;
        r.empty_res    = 1'b0;
        r.overflow     = dropped_flag;
        return r;
    endfunction

    // a load appends or sets the drop flag; a go runs the two-pointer walk
    task automatic predict_merge_results(engine_item_t it);
        merge_out_t               walk_q[$];
        merge_out_t               r;
        int unsigned              i;
        int unsigned              j;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        if (!it.go)
        begin
            if (!it.list_select)
            begin
                if (first_count < LIST_DEPTH)
                begin
                    first_list[first_count] = it.value;
                    first_count++;
                end
                else
                    dropped_flag = 1'b1;
            end
            else
            begin
                if (second_count < LIST_DEPTH)
                begin
                    second_list[second_count] = it.value;
                    second_count++;
                end
                else
                    dropped_flag = 1'b1;
            end
            return;
        end
        i = 0;
        j = 0;
        // signed compares, lists walked as loaded, sorted or not
        while (i < first_count && j < second_count)
        begin
            a = first_list[i];
            b = second_list[j];
            if (a < b)
            begin
                if (active_op != OP_INTERSECT)
                    walk_q.push_back(element_out(a));
                i++;
            end
            else if (b < a)
            begin
                if (active_op == OP_MERGE || active_op == OP_UNION)
                    walk_q.push_back(element_out(b));
                j++;
            end
            else
            begin
                case (active_op)
                    OP_MERGE:
                    begin
                        // tie in merge: second list goes first
                        walk_q.push_back(element_out(b));
                        j++;
                    end
                    OP_UNION, OP_INTERSECT:
                    begin
                        walk_q.push_back(element_out(a));
                        i++;
                        j++;
                    end
                    default:
                    begin
                        i++;
                        j++;
                    end
                endcase
            end
        end
        if (active_op != OP_INTERSECT)
            for (; i < first_count; i++)
                walk_q.push_back(element_out(first_list[i]));
        if (active_op == OP_MERGE || active_op == OP_UNION)
            for (; j < second_count; j++)
                walk_q.push_back(element_out(second_list[j]));
        // empty result still yields one transaction
        if (walk_q.size() == 0)
        begin
            r           = element_out('0);
            r.empty_res = 1'b1;
            walk_q.push_back(r);
        end
        walk_q[walk_q.size() - 1].last = 1'b1;
        foreach (walk_q[k])
            predicted_elements.push_back(walk_q[k]);
        first_count  = 0;
        second_count = 0;
        dropped_flag = 1'b0;
    endtask

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            go          <= 1'b0;
            list_select <= 1'b0;
            value       <= '0;
        end
        else
        begin
            // predict at the edge that takes the transaction
            if (item_valid && !item_stall)
            begin
                accepted_item.go          = go;
                accepted_item.list_select = list_select;
                accepted_item.value       = value;
                predict_merge_results(accepted_item);
                items_accepted++;
            end
            // payload only moves once the current one is gone
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0 || items_to_send.size() == 0)
                begin
                    item_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    next_item = items_to_send.pop_front();
                    item_valid  <= 1'b1;
                    go          <= next_item.go;
                    list_select <= next_item.list_select;
                    value       <= next_item.value;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 32);
                        // a third of the bursts run straight into the next
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall rate changes per window, plus the long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_grants != hold_requests)
        begin
            hold_grants  = hold_requests;
            hold_left    = LONG_HOLD;
            result_stall <= 1'b1;
        end
        else
        begin
            if (window_left <= 0)
            begin
                window_left = $urandom_range(16, 80);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            window_left--;
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: each accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        merge_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_elements.size() == 0)
                report_mismatch($sformatf("unexpected result: value %0d last %0b empty %0b ovf %0b",
                                          result_value, last, empty_res, overflow));
            else
            begin
                want = predicted_elements.pop_front();
                if (result_value !== want.result_value || last !== want.last ||
                    empty_res !== want.empty_res || overflow !== want.overflow)
                    report_mismatch($sformatf(
                        "mismatch: exp %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b (value/last/empty/ovf)",
                        want.result_value, want.last, want.empty_res, want.overflow,
                        result_value, last, empty_res, overflow));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(engine_item_t it);
        items_to_send.push_back(it);
        items_queued++;
    endtask

    // loads of both lists interleaved at random, then the go
    task automatic push_walk(elem_q_t l1, elem_q_t l2);
        engine_item_t it;
        int           i;
        int           j;
        i = 0;
        j = 0;
        while (i < l1.size() || j < l2.size())
        begin
            it.go = 1'b0;
            if (j >= l2.size() || (i < l1.size() && $urandom_range(0, 1) == 0))
            begin
                it.list_select = 1'b0;
                it.value       = l1[i];
                i++;
            end
            else
            begin
                it.list_select = 1'b1;
                it.value       = l2[j];
                j++;
            end
            push_item(it);
        end
        // list and value are don't-care on a go, so scramble them
        it.go          = 1'b1;
        it.list_select = $urandom_range(0, 1);
        it.value       = $urandom;
        push_item(it);
    endtask

    function automatic elem_q_t sorted_copy(elem_q_t q);
        logic signed [DATA_W-1:0] t;
        int                       k;
        for (int i = 1; i < q.size(); i++)
        begin
            t = q[i];
            k = i - 1;
            while (k >= 0 && q[k] > t)
            begin
                q[k + 1] = q[k];
                k--;
            end
            q[k + 1] = t;
        end
        return q;
    endfunction

    // mostly short lists, some full size, a few past the depth
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 8);
        else if (r < 9)
            return $urandom_range(0, LIST_DEPTH);
        return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
    endfunction

    task automatic push_random_walk();
        elem_q_t                  l1;
        elem_q_t                  l2;
        int                       n1;
        int                       n2;
        logic                     narrow;
        logic signed [DATA_W-1:0] base;
        n1     = pick_length();
        n2     = pick_length();
        // narrow windows give plenty of equal pairs
        narrow = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
            0:       base = 32'sh8000_0000;
            1:       base = 32'sh7fff_ffe0;
            default: base = $urandom;
        endcase
        repeat (n1)
            l1.push_back(narrow ? base + $urandom_range(0, 20) : $urandom);
        repeat (n2)
            l2.push_back(narrow ? base + $urandom_range(0, 20) : $urandom);
        // one walk in ten runs on lists as loaded, unsorted
        if ($urandom_range(0, 9) != 0)
        begin
            l1 = sorted_copy(l1);
            l2 = sorted_copy(l2);
        end
        push_walk(l1, l2);
    endtask

    // all transactions taken, all results seen, then a walk's worth of quiet
    task automatic wait_for_drain();
        while (items_accepted != items_queued || predicted_elements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_set_op(set_op_t op);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SET_OP;
        pwdata  <= APB_DATA_W'(op);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_op = op;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        elem_q_t l1;
        elem_q_t l2;
        int      phase;
        int      random_target;
        int      phase_end;
        set_op_t op;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // merge: extremes on both lists, ties on both ends
        write_set_op(OP_MERGE);
        l1 = '{32'sh8000_0000, 32'sh7fff_ffff};
        l2 = '{32'sh8000_0000, 32'sh7fff_ffff};
        push_walk(l1, l2);
        wait_for_drain();

        // union: shared element taken once
        write_set_op(OP_UNION);
        l1 = '{-3, 0};
        l2 = '{0, 9};
        push_walk(l1, l2);
        wait_for_drain();

        // intersection of two empty lists: empty result
        write_set_op(OP_INTERSECT);
        l1 = {};
        l2 = {};
        push_walk(l1, l2);
        wait_for_drain();

        // difference with the first list loaded one past full
        write_set_op(OP_DIFF);
        l1 = {};
        for (int k = 0; k < LIST_DEPTH + 1; k++)
            l1.push_back(k * 3 - 20);
        push_walk(l1, l2);
        wait_for_drain();

        // random phases, each under one operation; the first four walk
        // through every code in order
        random_target = items_queued + RANDOM_ITEMS;
        phase         = 0;
        while (items_queued < random_target)
        begin
            op = (phase < 4) ? set_op_t'(phase) : set_op_t'($urandom_range(0, 3));
            write_set_op(op);
            // receiver goes quiet while the sender keeps offering
            if (phase == 5)
                hold_requests++;
            phase_end = items_queued + PHASE_ITEMS;
            while (items_queued < phase_end && items_queued < random_target)
            begin
                push_random_walk();
                // now and then the sender waits out every pending result
                if ($urandom_range(0, 9) == 0)
                    wait_for_drain();
            end
            wait_for_drain();
            phase++;
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
